[design/c2d_pkg.sv]
// Shared types and constants of the clamp-to-edge 2D convolution block.
package c2d_pkg;

	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int MAX_KERNEL_DEF  = 5;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COEF_BITS_DEF   = 16;
	localparam int ACC_BITS_DEF    = 40;

	localparam int FIFO_DEPTH = 16;

	localparam logic [1:0] REQ_COEF   = 2'd0;
	localparam logic [1:0] REQ_SAMPLE = 2'd1;
	localparam logic [1:0] REQ_FLUSH  = 2'd2;
	localparam logic [1:0] REQ_NONE   = 2'd3;

	localparam logic [2:0] CFG_WIDTH  = 3'd0;
	localparam logic [2:0] CFG_HEIGHT = 3'd1;
	localparam logic [2:0] CFG_KROWS  = 3'd2;
	localparam logic [2:0] CFG_KCOLS  = 3'd3;
	localparam logic [2:0] CFG_FRAC   = 3'd4;

	localparam logic [10:0] RST_WIDTH  = 11'd1024;
	localparam logic [15:0] RST_HEIGHT = 16'd1024;
	localparam logic [2:0]  RST_KROWS  = 3'd3;
	localparam logic [2:0]  RST_KCOLS  = 3'd3;
	localparam logic [3:0]  RST_FRAC   = 4'd8;

	typedef struct packed {
		logic        vld;
		logic        last;
		logic [15:0] row;
		logic [9:0]  col;
	} meta_t;

	typedef struct packed {
		logic        last;
		logic        sat;
		logic [15:0] value;
		logic [9:0]  col;
		logic [15:0] row;
	} res_t;

	typedef struct packed {
		logic shift;
		logic load_all;
		logic en;
	} cell_ctl_t;

endpackage

[design/c2d_line_ram.sv]
// One row slot of the line store: single write port, registered read.
module c2d_line_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

endmodule

[design/c2d_cell.sv]
// Window cell: holds one column of taps, shifts from its neighbor, gives a column partial sum.
module c2d_cell #(
	parameter int K  = 5,
	parameter int SB = 16,
	parameter int CB = 16,
	parameter int AB = 40
) (
	input  logic                clk,
	input  c2d_pkg::cell_ctl_t  ctl,
	input  logic [SB-1:0]       new_col [K],
	input  logic [SB-1:0]       nb_col [K],
	input  logic [CB-1:0]       coef [K],
	input  logic [K-1:0]        row_en,
	output logic [SB-1:0]       col_q [K],
	output logic [AB-1:0]       psum_s4
);

	logic signed [SB+CB-1:0] prod [K];
	logic [AB-1:0]           prod_s3 [K];
	logic [AB-1:0]           sum_c;

	always_comb begin
		for (int i = 0; i < K; i++) begin
			prod[i] = $signed(col_q[i]) * $signed(coef[i]);
		end
	end

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < K; i++) begin
			sum_c = sum_c + prod_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < K; i++) begin
			if (ctl.shift) begin
				col_q[i] <= ctl.load_all ? new_col[i] : nb_col[i];
			end
			prod_s3[i] <= (ctl.en && row_en[i]) ? AB'(prod[i]) : '0;
		end
		psum_s4 <= sum_c;
	end

endmodule

[design/conv2d_clamp_edge.sv]
// Top level of the streaming 2D convolution with clamp-to-edge border.
//
// Load coefficients with coefficient items, then stream the frame in raster order
// followed by kernel_rows/2 rows of flush items. The block takes one item per cycle
// while tready is high. After the last item of a row that yields results it holds tready
// low while the window cells replay the right edge column to release the rest of that
// row's results; it also holds tready low while 16 results are pending. Results leave
// through a 16-entry output queue that lets input keep flowing while the output side
// stalls. Latency is set by the line store read, the window shift, the tap multipliers
// and two adder stages. Config writes to indices 0 to 4 restart the frame position.
module conv2d_clamp_edge #(
	parameter int MAX_WIDTH   = c2d_pkg::MAX_WIDTH_DEF,
	parameter int MAX_KERNEL  = c2d_pkg::MAX_KERNEL_DEF,
	parameter int SAMPLE_BITS = c2d_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_BITS   = c2d_pkg::COEF_BITS_DEF,
	parameter int ACC_BITS    = c2d_pkg::ACC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // coef_row[2:0], coef_col[5:3], sample_value[21:6]
	input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // out_row[15:0], out_col[25:16], out_value[41:26]
	output logic [0:0]  m_axis_tuser,   // saturated[0]
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data
);

	localparam int K  = MAX_KERNEL;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int SW = (K > 1) ? $clog2(K) : 1;
	localparam int HALF = K / 2;
	localparam int FW = $clog2(c2d_pkg::FIFO_DEPTH);
	localparam int PW = FW + 1;
	localparam int MW = ((ACC_BITS > SAMPLE_BITS) ? ACC_BITS : SAMPLE_BITS) + 1;
	localparam logic signed [MW-1:0] SAT_HI = MW'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
	localparam logic signed [MW-1:0] SAT_LO = -SAT_HI - 1;

	// configuration
	logic [10:0] cfg_w_q;
	logic [15:0] cfg_h_q;
	logic [2:0]  cfg_kr_q, cfg_kc_q;
	logic [3:0]  cfg_f_q;
	logic        cfg_hit;

	logic [CW:0]          eff_w;
	logic [15:0]          eff_h;
	logic [16:0]          row_lim;
	logic [SW-1:0]        hr, hc;
	logic signed [18:0]   hm1;

	// stream position
	logic [16:0]          vr_q;
	logic [CW-1:0]        vc_q;
	logic [SW-1:0]        slot_q;
	logic [SW-1:0]        rep_left_q;
	logic signed [CW+1:0] rep_col_q;
	logic [15:0]          rep_row_q;
	logic [PW-1:0]        pend_q;

	logic [1:0]             req;
	logic [2:0]             crow, ccol;
	logic [15:0]            sval;
	logic                   acc_in, in_frame, step, row_end, has_row, res_now;
	logic                   rep_go, rep_res, iss, pend_ok;
	logic [15:0]            r_now;
	logic [SW-1:0]          sel_c [K];

	logic [COEF_BITS-1:0]   coef_q [K][K];
	logic [COEF_BITS-1:0]   cmap_q [K][K];

	// window update stage
	logic [SW-1:0]          sel_s1 [K];
	logic                   wr_s1, shift_s1, load_s1, rep_s1;
	logic [SW-1:0]          wslot_s1;
	logic [SAMPLE_BITS-1:0] smp_s1;
	logic [SAMPLE_BITS-1:0] ram_q [K];
	logic [SAMPLE_BITS-1:0] newcol [K];
	logic [SAMPLE_BITS-1:0] win [K][K];
	logic [ACC_BITS-1:0]    psum [K];
	c2d_pkg::cell_ctl_t     ctl_c [K];
	logic [K-1:0]           row_en;

	c2d_pkg::meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;
	logic [ACC_BITS-1:0]        tot_c, tot_s5;
	logic signed [ACC_BITS-1:0] shf;
	logic signed [MW-1:0]       ext, qv;
	logic                       sat;

	c2d_pkg::res_t  fifo_q [c2d_pkg::FIFO_DEPTH];
	c2d_pkg::res_t  head;
	logic [FW-1:0]  wp_q, rp_q;
	logic [PW-1:0]  cnt_q;
	logic           push, pop;

	always_comb begin
		if (cfg_w_q == '0) begin
			eff_w = (CW+1)'(1);
		end else if (32'(cfg_w_q) > MAX_WIDTH) begin
			eff_w = (CW+1)'(MAX_WIDTH);
		end else begin
			eff_w = (CW+1)'(cfg_w_q);
		end
		eff_h = (cfg_h_q == '0) ? 16'd1 : cfg_h_q;
		hr = (32'(cfg_kr_q >> 1) > HALF) ? SW'(HALF) : SW'(cfg_kr_q >> 1);
		hc = (32'(cfg_kc_q >> 1) > HALF) ? SW'(HALF) : SW'(cfg_kc_q >> 1);
	end

	assign row_lim = {1'b0, eff_h} + 17'(hr);
	assign hm1 = 19'({3'b000, eff_h}) - 19'd1;

	assign req  = s_axis_tuser;
	assign crow = s_axis_tdata[2:0];
	assign ccol = s_axis_tdata[5:3];
	assign sval = s_axis_tdata[21:6];

	assign pend_ok = pend_q < PW'(c2d_pkg::FIFO_DEPTH);
	assign s_axis_tready = (rep_left_q == '0) && pend_ok;
	assign acc_in = s_axis_tvalid && s_axis_tready;
	assign in_frame = vr_q < {1'b0, eff_h};
	assign step = acc_in && (((req == c2d_pkg::REQ_SAMPLE) && in_frame) ||
		((req == c2d_pkg::REQ_FLUSH) && !in_frame));
	assign row_end = (({1'b0, vc_q}) + (CW+1)'(1)) == eff_w;
	assign has_row = vr_q >= 17'(hr);
	assign res_now = step && has_row && (32'(vc_q) >= 32'(hc));
	assign r_now = 16'(vr_q - 17'(hr));
	assign rep_go = (rep_left_q != '0) && pend_ok;
	assign rep_res = rep_go && !rep_col_q[CW+1];
	assign iss = res_now || rep_res;
	assign cfg_hit = cfg_we && (cfg_idx <= c2d_pkg::CFG_FRAC);

	// line store slot feeding each tap row, with the row clamped to the frame
	always_comb begin
		logic signed [18:0] tt;
		logic [SW-1:0]      d;
		logic [SW:0]        wrap;
		for (int i = 0; i < K; i++) begin
			tt = 19'({2'b00, vr_q}) + 19'(i) - 19'({hr, 1'b0});
			wrap = '0;
			if (tt < 0) begin
				d = SW'(vr_q);
			end else if (tt > hm1) begin
				d = SW'(vr_q - {1'b0, eff_h} + 17'd1);
			end else begin
				d = SW'({hr, 1'b0}) - SW'(i);
			end
			if (i > int'({hr, 1'b0})) begin
				sel_c[i] = '0;
			end else if (slot_q >= d) begin
				sel_c[i] = slot_q - d;
			end else begin
				wrap = {1'b0, slot_q} + (SW+1)'(K) - {1'b0, d};
				sel_c[i] = wrap[SW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q    <= c2d_pkg::RST_WIDTH;
			cfg_h_q    <= c2d_pkg::RST_HEIGHT;
			cfg_kr_q   <= c2d_pkg::RST_KROWS;
			cfg_kc_q   <= c2d_pkg::RST_KCOLS;
			cfg_f_q    <= c2d_pkg::RST_FRAC;
			vr_q       <= '0;
			vc_q       <= '0;
			slot_q     <= '0;
			rep_left_q <= '0;
			rep_col_q  <= '0;
			rep_row_q  <= '0;
			pend_q     <= '0;
		end else begin
			pend_q <= pend_q + PW'(iss) - PW'(pop);
			if (cfg_we) begin
				case (cfg_idx)
					c2d_pkg::CFG_WIDTH:  cfg_w_q  <= cfg_data[10:0];
					c2d_pkg::CFG_HEIGHT: cfg_h_q  <= cfg_data;
					c2d_pkg::CFG_KROWS:  cfg_kr_q <= cfg_data[2:0];
					c2d_pkg::CFG_KCOLS:  cfg_kc_q <= cfg_data[2:0];
					c2d_pkg::CFG_FRAC:   cfg_f_q  <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (cfg_hit) begin
				vr_q       <= '0;
				vc_q       <= '0;
				slot_q     <= '0;
				rep_left_q <= '0;
			end else if (step) begin
				if (row_end) begin
					vc_q <= '0;
					if (vr_q + 17'd1 >= row_lim) begin
						vr_q   <= '0;
						slot_q <= '0;
					end else begin
						vr_q   <= vr_q + 17'd1;
						slot_q <= (slot_q == SW'(K-1)) ? '0 : slot_q + SW'(1);
					end
					if (has_row && hc != '0) begin
						rep_left_q <= hc;
						rep_col_q  <= (CW+2)'({2'b00, vc_q}) + (CW+2)'(1) - (CW+2)'(hc);
						rep_row_q  <= r_now;
					end
				end else begin
					vc_q <= vc_q + CW'(1);
				end
			end else if (rep_go) begin
				rep_left_q <= rep_left_q - SW'(1);
				rep_col_q  <= rep_col_q + (CW+2)'(1);
			end
		end
	end

	// coefficients and their per-cell mapping
	always_ff @(posedge clk) begin
		int jj;
		if (acc_in && req == c2d_pkg::REQ_COEF && 32'(crow) < K && 32'(ccol) < K) begin
			coef_q[SW'(crow)][SW'(ccol)] <= COEF_BITS'(sval);
		end
		for (int m = 0; m < K; m++) begin
			jj = m - (K - 1) + int'({hc, 1'b0});
			for (int i = 0; i < K; i++) begin
				if (jj >= 0 && i <= int'({hr, 1'b0})) begin
					cmap_q[m][i] <= coef_q[i][SW'(jj)];
				end else begin
					cmap_q[m][i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_s1 <= 1'b0;
			load_s1  <= 1'b0;
			rep_s1   <= 1'b0;
			wr_s1    <= 1'b0;
			meta_s1  <= '0;
			meta_s2  <= '0;
			meta_s3  <= '0;
			meta_s4  <= '0;
			meta_s5  <= '0;
		end else begin
			shift_s1 <= step || rep_go;
			load_s1  <= step && (vc_q == '0);
			rep_s1   <= rep_go && !step;
			wr_s1    <= step && (req == c2d_pkg::REQ_SAMPLE);
			if (step) begin
				meta_s1.vld  <= res_now;
				meta_s1.last <= !(row_end && hc != '0);
				meta_s1.row  <= r_now;
				meta_s1.col  <= 10'(vc_q - CW'(hc));
			end else begin
				meta_s1.vld  <= rep_res;
				meta_s1.last <= rep_left_q == SW'(1);
				meta_s1.row  <= rep_row_q;
				meta_s1.col  <= 10'(rep_col_q[CW-1:0]);
			end
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
		end
	end

	always_ff @(posedge clk) begin
		sel_s1   <= sel_c;
		wslot_s1 <= slot_q;
		smp_s1   <= SAMPLE_BITS'(sval);
		tot_s5   <= tot_c;
	end

	for (genvar k = 0; k < K; k++) begin : g_ram
		c2d_line_ram #(
			.DEPTH(MAX_WIDTH),
			.WIDTH(SAMPLE_BITS)
		) u_ram (
			.clk     (clk),
			.we      (step && req == c2d_pkg::REQ_SAMPLE && slot_q == SW'(k)),
			.re      (step),
			.addr    (vc_q),
			.wdata   (SAMPLE_BITS'(sval)),
			.rdata_q (ram_q[k])
		);
	end

	// new column, with the sample written in the same cycle taken directly
	always_comb begin
		for (int i = 0; i < K; i++) begin
			newcol[i] = (wr_s1 && sel_s1[i] == wslot_s1) ? smp_s1 : ram_q[sel_s1[i]];
			row_en[i] = i <= int'({hr, 1'b0});
		end
		for (int m = 0; m < K; m++) begin
			ctl_c[m].shift    = shift_s1;
			ctl_c[m].load_all = load_s1;
			ctl_c[m].en       = m >= (K - 1 - int'({hc, 1'b0}));
		end
	end

	for (genvar m = 0; m < K; m++) begin : g_cell
		logic [SAMPLE_BITS-1:0] nb [K];
		if (m == K - 1) begin : g_end
			always_comb begin
				for (int i = 0; i < K; i++) begin
					nb[i] = rep_s1 ? win[m][i] : newcol[i];
				end
			end
		end else begin : g_mid
			assign nb = win[m+1];
		end
		c2d_cell #(
			.K (K),
			.SB(SAMPLE_BITS),
			.CB(COEF_BITS),
			.AB(ACC_BITS)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl_c[m]),
			.new_col (newcol),
			.nb_col  (nb),
			.coef    (cmap_q[m]),
			.row_en  (row_en),
			.col_q   (win[m]),
			.psum_s4 (psum[m])
		);
	end

	always_comb begin
		tot_c = '0;
		for (int m = 0; m < K; m++) begin
			tot_c = tot_c + psum[m];
		end
	end

	// floor shift, then saturate to the sample range
	always_comb begin
		shf = $signed(tot_s5) >>> cfg_f_q;
		ext = MW'(shf);
		sat = 1'b0;
		qv  = ext;
		if (ext > SAT_HI) begin
			qv  = SAT_HI;
			sat = 1'b1;
		end else if (ext < SAT_LO) begin
			qv  = SAT_LO;
			sat = 1'b1;
		end
	end

	assign push = meta_s5.vld;
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q].last  <= meta_s5.last;
			fifo_q[wp_q].sat   <= sat;
			fifo_q[wp_q].value <= 16'(qv);
			fifo_q[wp_q].col   <= meta_s5.col;
			fifo_q[wp_q].row   <= meta_s5.row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + FW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + FW'(1);
			end
			cnt_q <= cnt_q + PW'(push) - PW'(pop);
		end
	end

	assign head = fifo_q[rp_q];
	assign m_axis_tvalid = cnt_q != '0;
	assign m_axis_tdata  = {6'b000000, head.value, head.col, head.row};
	assign m_axis_tuser  = head.sat;
	assign m_axis_tlast  = head.last;

endmodule

[bench/conv2d_clamp_edge_test.sv]
// Self-checking testbench for the clamp-to-edge 2D convolution block.
`timescale 1ns / 100ps

module conv2d_clamp_edge_test;

	localparam int MW = 1024;
	localparam int MK = 5;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [1:0]  kind;
		logic [2:0]  crow;
		logic [2:0]  ccol;
		logic [15:0] val;
	} item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_idx = '0;
	logic [15:0] cfg_data = '0;

	conv2d_clamp_edge dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	item_t         stim_q[$];
	c2d_pkg::res_t conv_q[$];
	int    errors = 0;
	int    n_items = 0;
	bit    quiet = 0;
	int    in_gap = 0;
	int    out_gap = 0;
	int    idle_cycles = 0;

	// predictor state
	logic [10:0] r_width;
	logic [15:0] r_height;
	logic [2:0]  r_krows, r_kcols;
	logic [3:0]  r_frac;
	logic signed [15:0] lines [MK][MW];
	logic signed [15:0] coefs [MK*MK];
	int in_row, in_col;

	function automatic int eff_w();
		if (r_width == 0) return 1;
		if (r_width > MW) return MW;
		return r_width;
	endfunction

	function automatic int eff_h();
		return (r_height == 0) ? 1 : r_height;
	endfunction

	function automatic int half(logic [2:0] k);
		return (k / 2 > MK / 2) ? MK / 2 : k / 2;
	endfunction

	function automatic c2d_pkg::res_t convolve(int r, int c, int w, int h, int hr, int hc);
		logic signed [39:0] acc;
		logic signed [39:0] q;
		int rr, cc;
		c2d_pkg::res_t o;
		acc = '0;
		for (int dr = -hr; dr <= hr; dr++) begin
			rr = r + dr;
			if (rr < 0) rr = 0;
			if (rr > h - 1) rr = h - 1;
			for (int dc = -hc; dc <= hc; dc++) begin
				cc = c + dc;
				if (cc < 0) cc = 0;
				if (cc > w - 1) cc = w - 1;
				acc = acc + 40'(lines[rr % MK][cc]) * 40'(coefs[(dr + hr) * MK + dc + hc]);
			end
		end
		q = acc >>> r_frac;
		o.sat = 1'b0;
		if (q > 40'sd32767) begin
			q = 40'sd32767;
			o.sat = 1'b1;
		end else if (q < -40'sd32768) begin
			q = -40'sd32768;
			o.sat = 1'b1;
		end
		o.row = r[15:0];
		o.col = c[9:0];
		o.value = q[15:0];
		o.last = 1'b0;
		return o;
	endfunction

	task automatic predict(item_t it);
		int w, h, hr, hc, vr, vc, first, last_c, n;
		w = eff_w();
		h = eff_h();
		hr = half(r_krows);
		hc = half(r_kcols);
		n = 0;
		if (it.kind == c2d_pkg::REQ_COEF) begin
			if (it.crow < MK && it.ccol < MK) coefs[it.crow * MK + it.ccol] = it.val;
			return;
		end
		if (it.kind != c2d_pkg::REQ_SAMPLE && it.kind != c2d_pkg::REQ_FLUSH) return;
		if (in_row >= h + hr) in_row = 0;
		if (in_col >= w) in_col = 0;
		vr = in_row;
		vc = in_col;
		if (it.kind == c2d_pkg::REQ_SAMPLE && vr >= h) return;
		if (it.kind == c2d_pkg::REQ_FLUSH && vr < h) return;
		if (it.kind == c2d_pkg::REQ_SAMPLE) lines[vr % MK][vc] = it.val;
		if (vr >= hr && vr - hr < h) begin
			first = vc - hc;
			last_c = (vc == w - 1) ? w - 1 : first;
			if (first < 0) first = 0;
			for (int c = first; c <= last_c; c++) begin
				conv_q.push_back(convolve(vr - hr, c, w, h, hr, hc));
				n++;
			end
		end
		if (n > 0) conv_q[conv_q.size() - 1].last = 1'b1;
		vc++;
		if (vc >= w) begin
			vc = 0;
			vr++;
			if (vr >= h + hr) vr = 0;
		end
		in_row = vr;
		in_col = vc;
	endtask

	// driver
	always @(posedge clk) begin
		item_t nx;
		logic  v;
		if (s_axis_tvalid && s_axis_tready) begin
			predict(stim_q.pop_front());
			n_items++;
		end
		v = 1'b0;
		if (s_axis_tvalid && !s_axis_tready) v = 1'b1;
		else if (in_gap > 0) in_gap--;
		else if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(0, 3);
		else if (stim_q.size() > 0) v = 1'b1;
		if (v) begin
			nx = stim_q[0];
			s_axis_tdata <= {2'b00, nx.val, nx.ccol, nx.crow};
			s_axis_tuser <= nx.kind;
		end
		s_axis_tvalid <= v;
	end

	// monitor
	always @(posedge clk) begin
		c2d_pkg::res_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (conv_q.size() == 0) begin
				$error("result with none expected: row %0d col %0d",
					m_axis_tdata[15:0], m_axis_tdata[25:16]);
				errors++;
			end else begin
				e = conv_q.pop_front();
				if (m_axis_tdata[15:0] !== e.row) begin
					$error("out_row exp %0d got %0d", e.row, m_axis_tdata[15:0]);
					errors++;
				end
				if (m_axis_tdata[25:16] !== e.col) begin
					$error("out_col exp %0d got %0d", e.col, m_axis_tdata[25:16]);
					errors++;
				end
				if (m_axis_tdata[41:26] !== e.value) begin
					$error("out_value exp %0d got %0d", $signed(e.value),
						$signed(m_axis_tdata[41:26]));
					errors++;
				end
				if (m_axis_tuser[0] !== e.sat) begin
					$error("saturated exp %0d got %0d", e.sat, m_axis_tuser[0]);
					errors++;
				end
				if (m_axis_tlast !== e.last) begin
					$error("last_of_run exp %0d got %0d", e.last, m_axis_tlast);
					errors++;
				end
			end
		end
		if (out_gap > 0) begin
			out_gap--;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			out_gap = $urandom_range(0, 3);
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic item_t mk(logic [1:0] kind, logic [2:0] cr, logic [2:0] cc,
			logic [15:0] v);
		item_t it;
		it.kind = kind;
		it.crow = cr;
		it.ccol = cc;
		it.val = v;
		return it;
	endfunction

	function automatic logic [15:0] rnd_val(bit narrow);
		return narrow ? 16'($urandom_range(0, 1023) - 512) : 16'($urandom);
	endfunction

	task automatic settle();
		wait (stim_q.size() == 0 && !s_axis_tvalid);
		wait (conv_q.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic cfg_write(logic [2:0] idx, logic [15:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v;
		case (idx)
			c2d_pkg::CFG_WIDTH:  r_width = v[10:0];
			c2d_pkg::CFG_HEIGHT: r_height = v;
			c2d_pkg::CFG_KROWS:  r_krows = v[2:0];
			c2d_pkg::CFG_KCOLS:  r_kcols = v[2:0];
			c2d_pkg::CFG_FRAC:   r_frac = v[3:0];
			default: ;
		endcase
		in_row = 0;
		in_col = 0;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(int w, int h, int kr, int kc, int f);
		settle();
		cfg_write(c2d_pkg::CFG_WIDTH, 16'(w));
		cfg_write(c2d_pkg::CFG_HEIGHT, 16'(h));
		cfg_write(c2d_pkg::CFG_KROWS, 16'(kr));
		cfg_write(c2d_pkg::CFG_KCOLS, 16'(kc));
		cfg_write(c2d_pkg::CFG_FRAC, 16'(f));
	endtask

	// one frame plus its flush rows, with some ignored or misplaced items mixed in
	task automatic queue_frame(int noise, bit narrow);
		int w, h, hr;
		w = eff_w();
		h = eff_h();
		hr = half(r_krows);
		for (int r = 0; r < h + hr; r++)
			for (int c = 0; c < w; c++) begin
				if (noise > 0 && $urandom_range(0, 99) < noise) begin
					case ($urandom_range(0, 3))
						0: stim_q.push_back(mk(c2d_pkg::REQ_NONE, 3'($urandom),
							3'($urandom), 16'($urandom)));
						1: stim_q.push_back(mk(c2d_pkg::REQ_COEF, 3'($urandom_range(0, 4)),
							3'($urandom_range(0, 4)), rnd_val(narrow)));
						2: stim_q.push_back(mk(c2d_pkg::REQ_COEF, 3'($urandom_range(5, 7)),
							3'($urandom), 16'($urandom)));
						default: stim_q.push_back(mk(r < h ? c2d_pkg::REQ_FLUSH :
							c2d_pkg::REQ_SAMPLE, 3'($urandom), 3'($urandom), 16'($urandom)));
					endcase
				end
				stim_q.push_back(mk(r < h ? c2d_pkg::REQ_SAMPLE : c2d_pkg::REQ_FLUSH,
					3'($urandom), 3'($urandom), rnd_val(narrow)));
			end
	endtask

	task automatic load_coefs(bit narrow);
		for (int i = 0; i < MK * MK; i++)
			stim_q.push_back(mk(c2d_pkg::REQ_COEF, 3'(i / MK), 3'(i % MK), rnd_val(narrow)));
	endtask

	initial begin
		bit narrow;
		int kr, kc;
		r_width = c2d_pkg::RST_WIDTH;
		r_height = c2d_pkg::RST_HEIGHT;
		r_krows = c2d_pkg::RST_KROWS;
		r_kcols = c2d_pkg::RST_KCOLS;
		r_frac = c2d_pkg::RST_FRAC;
		in_row = 0;
		in_col = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every tap, value extremes, ignored loads and requests
		for (int i = 0; i < MK * MK; i++)
			stim_q.push_back(mk(c2d_pkg::REQ_COEF, 3'(i / MK), 3'(i % MK),
				(i % 3 == 0) ? 16'h7fff : (i % 3 == 1) ? 16'h8000 : 16'h0100));
		stim_q.push_back(mk(c2d_pkg::REQ_COEF, 3'd7, 3'd7, 16'hffff));
		stim_q.push_back(mk(c2d_pkg::REQ_NONE, 3'd7, 3'd7, 16'hffff));
		configure(3, 2, 5, 5, 0);
		stim_q.push_back(mk(c2d_pkg::REQ_FLUSH, 3'd0, 3'd0, 16'h0));
		stim_q.push_back(mk(c2d_pkg::REQ_SAMPLE, 3'd0, 3'd0, 16'h7fff));
		stim_q.push_back(mk(c2d_pkg::REQ_SAMPLE, 3'd0, 3'd0, 16'h8000));
		stim_q.push_back(mk(c2d_pkg::REQ_SAMPLE, 3'd0, 3'd0, 16'h0000));
		stim_q.push_back(mk(c2d_pkg::REQ_SAMPLE, 3'd0, 3'd0, 16'hffff));
		stim_q.push_back(mk(c2d_pkg::REQ_SAMPLE, 3'd0, 3'd0, 16'h0001));
		stim_q.push_back(mk(c2d_pkg::REQ_SAMPLE, 3'd0, 3'd0, 16'h7fff));
		stim_q.push_back(mk(c2d_pkg::REQ_SAMPLE, 3'd0, 3'd0, 16'h1234));
		for (int i = 0; i < 6; i++)
			stim_q.push_back(mk(c2d_pkg::REQ_FLUSH, 3'd0, 3'd0, 16'h0));
		configure(0, 0, 0, 0, 15);
		queue_frame(0, 0);
		configure(2047, 1, 1, 5, 4);
		for (int i = 0; i < 40; i++)
			stim_q.push_back(mk(c2d_pkg::REQ_SAMPLE, 3'($urandom), 3'($urandom),
				rnd_val(1)));
		configure(1, 65535, 5, 4, 8);
		for (int i = 0; i < 10; i++)
			stim_q.push_back(mk(c2d_pkg::REQ_SAMPLE, 3'($urandom), 3'($urandom),
				rnd_val(1)));

		// random frames
		while (n_items < 480) begin
			if (n_items > 360) quiet = 1;
			narrow = $urandom_range(0, 3) != 0;
			kr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : 2 * $urandom_range(0, 2) + 1;
			kc = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : 2 * $urandom_range(0, 2) + 1;
			configure($urandom_range(1, 12), $urandom_range(1, 6), kr, kc,
				narrow ? $urandom_range(0, 6) : $urandom_range(0, 15));
			load_coefs(narrow);
			repeat ($urandom_range(1, 2)) queue_frame($urandom_range(0, 1) ? 8 : 0, narrow);
			settle();
		end

		settle();
		if (errors == 0 && conv_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
